/* hw/rtl/hps_pkg.sv */
// shared types, constants and helper tables for the heaviside projection sum unit
// no dependencies
`timescale 1ns / 1ps

package hps_pkg;

  // fixed point widths and constants
  localparam int unsigned DensW      = 17;
  localparam int unsigned SumW       = 34;
  localparam logic [16:0] OneQ16     = 17'd65536;
  localparam int unsigned MaxCellsDef = 65536;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned LastTerm   = 13;

  // e^(-1) in Q0.32 as the truncated series produces it
  localparam logic [32:0] ExpOneQ32 = 33'd1580030169;

  // configuration register indexes
  typedef enum logic {
    CfgThreshold = 1'b0,
    CfgSharpness = 1'b1
  } cfg_idx_e;

  // one classified cell travelling from front to back
  typedef struct packed {
    logic        low_side; // density at or below the threshold
    logic [16:0] dens;     // saturated density
    logic [15:0] eta;      // threshold, never zero
    logic [15:0] sharp;    // sharpness in Q8.8
    logic [15:0] num;      // ratio numerator
    logic [15:0] den;      // ratio denominator
    logic        last;
  } cell_req_t;

  typedef enum logic [2:0] {
    ExIdle,
    ExMul,
    ExRecip,
    ExFix,
    ExPowMul,
    ExPowAdd,
    ExRound,
    ExDone
  } exp_state_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkDiv,
    BkWaitEb,
    BkArg,
    BkWaitE,
    BkMul1,
    BkMul2,
    BkAcc
  } back_state_e;

  // ceil(2^32 / k) for the series divisors
  function automatic logic [32:0] recip_q32(input logic [3:0] k);
    logic [32:0] r;
    case (k)
      4'd1:    r = 33'd4294967296;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655766;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993460;
      4'd6:    r = 33'd715827883;
      4'd7:    r = 33'd613566757;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218589;
      4'd10:   r = 33'd429496730;
      4'd11:   r = 33'd390451573;
      4'd12:   r = 33'd357913942;
      4'd13:   r = 33'd330382100;
      default: r = 33'd4294967296;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/hps_front.sv */
// front end: takes cell requests, saturates the density and picks the projection branch
// depends on hps_pkg
`timescale 1ns / 1ps

module hps_front (
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,   // [16:0] density
  input  logic               s_axis_tlast,   // last_cell
  input  logic [15:0]        threshold_i,
  input  logic [15:0]        sharpness_i,
  input  logic               full_i,
  output logic               push_o,
  output hps_pkg::cell_req_t req_o
);
  import hps_pkg::*;

  logic [16:0] dens;
  logic [15:0] eta;
  logic        low_side;

  // handshake towards the queue
  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  // saturate density and fix a zero threshold
  assign dens     = (s_axis_tdata[16:0] > OneQ16) ? OneQ16 : s_axis_tdata[16:0];
  assign eta      = (threshold_i == 16'd0) ? 16'd1 : threshold_i;
  assign low_side = dens <= {1'b0, eta};

  // ratio operands for the chosen branch
  always_comb begin
    req_o.low_side = low_side;
    req_o.dens     = dens;
    req_o.eta      = eta;
    req_o.sharp    = sharpness_i;
    req_o.last     = s_axis_tlast;
    if (low_side) begin
      req_o.num = dens[15:0];
      req_o.den = eta;
    end else begin
      req_o.num = 16'(dens - {1'b0, eta});
      req_o.den = 16'(OneQ16 - {1'b0, eta});
    end
  end

endmodule

/* hw/rtl/hps_queue.sv */
// short request queue between front and back
// depends on hps_pkg
`timescale 1ns / 1ps

module hps_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hps_pkg::cell_req_t req_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output hps_pkg::cell_req_t req_o
);
  import hps_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cell_req_t       entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = count_q == CntW'(QueueDepth);
  assign valid_o = count_q != '0;
  assign req_o   = entry_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= req_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth)) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");

endmodule

/* hw/rtl/hps_exp.sv */
// sequential e^(-x) unit: truncated taylor series, repeated e^(-1) products, rounding
// depends on hps_pkg
`timescale 1ns / 1ps

module hps_exp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [24:0] arg_i,    // x in Q.16
  output logic        valid_o,
  output logic [16:0] res_o     // e^(-x) in Q0.16
);
  import hps_pkg::*;

  exp_state_e  state_q, state_d;
  logic [32:0] term_q, acc_q;
  logic [15:0] frac_q;
  logic [3:0]  k_q;
  logic [4:0]  n_q;
  logic [48:0] mul_q;
  logic [31:0] v_q;
  logic [64:0] rp_q;
  logic [63:0] pw_q;
  logic [16:0] res_q;

  logic        too_big;
  logic [32:0] qe;
  logic [36:0] qk;
  logic [32:0] quot;
  logic [63:0] pw_rnd;
  logic [32:0] acc_rnd;

  assign too_big = arg_i[24:16] > 9'd16;

  // corrected reciprocal quotient and rounding helpers
  always_comb begin
    qe      = rp_q[64:32];
    qk      = 37'(qe) * 37'(k_q);
    quot    = (qk > 37'(v_q)) ? qe - 33'd1 : qe;
    pw_rnd  = pw_q + 64'd2147483648;
    acc_rnd = acc_q + 33'd32768;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ExIdle, ExDone: begin
        if (start_i) state_d = too_big ? ExDone : ExMul;
      end
      ExMul:   state_d = ExRecip;
      ExRecip: state_d = ExFix;
      ExFix: begin
        if (k_q == 4'(LastTerm)) state_d = (n_q == 5'd0) ? ExRound : ExPowMul;
        else                     state_d = ExMul;
      end
      ExPowMul: state_d = ExPowAdd;
      ExPowAdd: state_d = (n_q == 5'd1) ? ExRound : ExPowMul;
      ExRound:  state_d = ExDone;
      default:  state_d = ExIdle;
    endcase
  end

  // outputs
  always_comb begin
    valid_o = state_q == ExDone;
    res_o   = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ExIdle;
    else         state_q <= state_d;
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ExIdle, ExDone: begin
        if (start_i) begin
          frac_q <= arg_i[15:0];
          n_q    <= arg_i[20:16];
          term_q <= 33'h1_0000_0000;
          acc_q  <= 33'h1_0000_0000;
          k_q    <= 4'd1;
          if (too_big) res_q <= '0;
        end
      end
      ExMul: mul_q <= 49'(term_q) * 49'(frac_q);
      ExRecip: begin
        v_q  <= mul_q[47:16];
        rp_q <= 65'(mul_q[47:16]) * 65'(recip_q32(k_q));
      end
      ExFix: begin
        term_q <= quot;
        acc_q  <= k_q[0] ? acc_q - quot : acc_q + quot;
        k_q    <= k_q + 4'd1;
      end
      ExPowMul: pw_q <= 64'(acc_q) * 64'(ExpOneQ32);
      ExPowAdd: begin
        acc_q <= {1'b0, pw_rnd[63:32]};
        n_q   <= n_q - 5'd1;
      end
      ExRound: res_q <= acc_rnd[32:16];
      default: ;
    endcase
  end

  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ExDone |-> res_q <= 17'd65536) else $error("exp result above one");
  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ExMul |-> acc_q <= 33'h1_0000_0000 && term_q <= 33'h1_0000_0000)
    else $error("series partial sum out of range");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ExFix |-> k_q >= 4'd1 && k_q <= 4'(LastTerm))
    else $error("series index out of range");

endmodule

/* hw/rtl/hps_back.sv */
// back end: ratio division, projection, accumulation and result register
// depends on hps_pkg, hps_exp
`timescale 1ns / 1ps

module hps_back #(
  parameter int unsigned MaxCells = hps_pkg::MaxCellsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  hps_pkg::cell_req_t req_i,
  output logic               pop_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [39:0]        m_axis_tdata    // [33:0] difference_sum
);
  import hps_pkg::*;

  localparam logic [63:0] CapRaw = 64'(MaxCells) << 16;
  localparam logic [33:0] Cap    = (CapRaw > 64'h1_FFFF_FFFF) ? 34'h1_FFFF_FFFF : CapRaw[33:0];

  back_state_e       state_q, state_d;
  cell_req_t         req_q;
  logic [16:0]       rem_q, quo_q, u_q, eb_q, e_q;
  logic [4:0]        cnt_q;
  logic [33:0]       prod_q;
  logic [32:0]       prod2_q;
  logic signed [33:0] sum_q;
  logic              out_valid_q;
  logic [33:0]       out_data_q;

  logic              exp_start, exp_valid;
  logic [24:0]       exp_arg;
  logic [16:0]       exp_res;
  logic [16:0]       shifted;
  logic              div_bit;
  logic [32:0]       arg_prod;
  logic [17:0]       sub, inner_raw;
  logic [16:0]       inner, coef;
  logic [17:0]       p_raw;
  logic [16:0]       p;
  logic signed [18:0] term;
  logic signed [34:0] s_raw;
  logic signed [33:0] s_sat;
  logic              out_free;
  logic              emit;

  hps_exp u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(exp_start),
    .arg_i  (exp_arg),
    .valid_o(exp_valid),
    .res_o  (exp_res)
  );

  // one restoring division step
  assign shifted = (cnt_q == 5'd16) ? rem_q : {rem_q[15:0], 1'b0};
  assign div_bit = shifted >= {1'b0, req_q.den};

  // projection arithmetic
  always_comb begin
    arg_prod  = 33'(req_q.sharp) * 33'(u_q);
    sub       = prod_q[33:16];
    if (req_q.low_side) begin
      inner_raw = ({1'b0, e_q} > sub) ? {1'b0, e_q} - sub : 18'd0;
      coef      = {1'b0, req_q.eta};
    end else begin
      inner_raw = {1'b0, OneQ16} - {1'b0, e_q} + sub;
      coef      = 17'(OneQ16 - {1'b0, req_q.eta});
    end
    inner = (inner_raw > {1'b0, OneQ16}) ? OneQ16 : inner_raw[16:0];
    p_raw = (req_q.low_side ? 18'd0 : 18'(req_q.eta)) + 18'(prod2_q[32:16]);
    p     = (p_raw > {1'b0, OneQ16}) ? OneQ16 : p_raw[16:0];
    term  = $signed({2'b0, req_q.dens}) - $signed({2'b0, p});
    s_raw = 35'(sum_q) + 35'(term);
    if (s_raw > $signed({1'b0, Cap}))       s_sat = $signed(Cap);
    else if (s_raw < -$signed({1'b0, Cap})) s_sat = -$signed(Cap);
    else                                    s_sat = s_raw[33:0];
  end

  assign out_free = !out_valid_q || m_axis_tready;
  assign emit     = (state_q == BkAcc) && req_q.last && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle:   if (req_valid_i) state_d = BkDiv;
      BkDiv:    if (cnt_q == 5'd0) state_d = BkWaitEb;
      BkWaitEb: if (exp_valid) state_d = BkArg;
      BkArg:    state_d = BkWaitE;
      BkWaitE:  if (exp_valid) state_d = BkMul1;
      BkMul1:   state_d = BkMul2;
      BkMul2:   state_d = BkAcc;
      BkAcc:    if (!req_q.last || out_free) state_d = BkIdle;
      default:  state_d = BkIdle;
    endcase
  end

  // outputs
  always_comb begin
    pop_o         = (state_q == BkIdle) && req_valid_i;
    exp_start     = 1'b0;
    exp_arg       = {1'b0, req_i.sharp, 8'd0};
    if (state_q == BkIdle) begin
      exp_start = req_valid_i;
    end else if (state_q == BkArg) begin
      exp_start = 1'b1;
      exp_arg   = arg_prod[32:8];
    end
    m_axis_tvalid = out_valid_q;
    m_axis_tdata  = {6'd0, out_data_q};
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= (out_valid_q && !m_axis_tready) || emit;
      if (state_q == BkAcc) begin
        if (!req_q.last) begin
          sum_q <= s_sat;
        end else if (out_free) begin
          sum_q <= '0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      BkIdle: begin
        if (req_valid_i) begin
          req_q <= req_i;
          rem_q <= {1'b0, req_i.num};
          quo_q <= '0;
          cnt_q <= 5'd16;
        end
      end
      BkDiv: begin
        quo_q <= {quo_q[15:0], div_bit};
        rem_q <= div_bit ? shifted - {1'b0, req_q.den} : shifted;
        cnt_q <= cnt_q - 5'd1;
      end
      BkWaitEb: begin
        if (exp_valid) begin
          eb_q <= exp_res;
          u_q  <= req_q.low_side ? OneQ16 - quo_q : quo_q;
        end
      end
      BkWaitE: if (exp_valid) e_q <= exp_res;
      BkMul1:  prod_q <= 34'(u_q) * 34'(eb_q);
      BkMul2:  prod2_q <= 33'(coef) * 33'(inner);
      BkAcc:   if (req_q.last && out_free) out_data_q <= s_sat;
      default: ;
    endcase
  end

  a_clear_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BkAcc && req_q.last && out_free |=> sum_q == '0 && out_valid_q)
    else $error("sum not cleared on emission");
  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BkWaitEb |-> quo_q <= OneQ16) else $error("ratio above one");
  a_sum_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= $signed(Cap) && sum_q >= -$signed(Cap)) else $error("sum beyond cap");

endmodule

/* hw/rtl/heaviside_projection_sum_unit.sv */
// top level of the heaviside projection sum unit: configuration registers and wiring
// depends on hps_pkg, hps_front, hps_queue, hps_back (with hps_exp)
`timescale 1ns / 1ps

// Each cell request carries a Q0.16 density; the unit projects it with an exponential
// smooth-Heaviside curve (threshold and sharpness from the configuration port), adds
// density minus projection to a saturating signed sum and returns that sum when a
// request with tlast arrives, clearing it afterwards. Requests enter a two-entry queue
// and are worked one at a time by the back end. The time per cell is set by the shared
// exponential unit, run twice per cell (for the sharpness and for the exponent argument)
// next to a restoring divider: a 13-term series with a multiply, reciprocal and fix step
// per term, then a multiply and add step per e^-1 product, one product per unit of the
// argument's integer part. An argument whose integer part is above 16 gives zero at once
// and shortens the cell.
module heaviside_projection_sum_unit #(
  parameter int unsigned MaxCells = hps_pkg::MaxCellsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [16:0] density
  input  logic        s_axis_tlast,   // last_cell
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [33:0] difference_sum
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import hps_pkg::*;

  logic [15:0] threshold_q, sharpness_q;
  logic        push, full, req_valid, pop;
  cell_req_t   front_req, queue_req;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= 16'd32768;
      sharpness_q <= 16'd2048;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgThreshold: threshold_q <= cfg_data_i;
        CfgSharpness: sharpness_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hps_front u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .threshold_i  (threshold_q),
    .sharpness_i  (sharpness_q),
    .full_i       (full),
    .push_o       (push),
    .req_o        (front_req)
  );

  hps_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .req_i  (front_req),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(req_valid),
    .req_o  (queue_req)
  );

  hps_back #(
    .MaxCells(MaxCells)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid),
    .req_i        (queue_req),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule
